// ===== hdl/source_text_tokenizer_macros.svh =====
// ----------------------------------------------------------------------------
// source text tokenizer assertion macros
// concurrent checks sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define STT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication
`define STT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`else

`define STT_ASSERT_IMP(label, ante, cons)
`define STT_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== hdl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// character classes, token type codes and matching helpers of the tokenizer
// ----------------------------------------------------------------------------
package stt_pkg;

    typedef enum logic [3:0] {
        CL_INVALID = 4'd0,
        CL_FORMAT  = 4'd1,
        CL_ALPHA   = 4'd2,
        CL_NUM     = 4'd3,
        CL_PAREN   = 4'd4,
        CL_BRACE   = 4'd5,
        CL_QUOTE   = 4'd6,
        CL_AMP     = 4'd7,
        CL_SEMI    = 4'd8,
        CL_HASH    = 4'd9,
        CL_AT      = 4'd10,
        CL_SYM     = 4'd11
    } char_class_t;

    typedef enum logic [4:0] {
        TT_IDENT    = 5'd0,
        TT_KEYWORD  = 5'd1,
        TT_LPAREN   = 5'd2,
        TT_RPAREN   = 5'd3,
        TT_LBRACE   = 5'd4,
        TT_RBRACE   = 5'd5,
        TT_ELLIPSIS = 5'd6,
        TT_INT      = 5'd7,
        TT_FLOAT    = 5'd8,
        TT_COMMA    = 5'd9,
        TT_OP       = 5'd10,
        TT_INVALID  = 5'd11,
        TT_STRING   = 5'd12,
        TT_AMP      = 5'd13,
        TT_SEMI     = 5'd14,
        TT_AT       = 5'd15,
        TT_HASH     = 5'd16,
        TT_ERROR    = 5'd17
    } tok_type_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // first eight token bytes, entry 0 is the first byte
    typedef logic [7:0][7:0] head8_t;

    // one emitted token
    typedef struct packed {
        tok_type_t   token_type;
        logic [31:0] line_number;
        logic [15:0] token_length;
    } tok_res_t;

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic char_class_t class_of(logic [7:0] c);
        char_class_t k;
        priority if (is_letter(c) || (c == CH_USCORE))
        begin
            k = CL_ALPHA;
        end
        else if (((c >= 8'h30) && (c <= 8'h39)) || (c == CH_DOT))
        begin
            k = CL_NUM;
        end
        else
        begin
            unique case (c)
                CH_LPAREN, CH_RPAREN:      k = CL_PAREN;
                CH_LBRACE, CH_RBRACE:      k = CL_BRACE;
                CH_SPACE, CH_LF, CH_TAB:   k = CL_FORMAT;
                CH_QUOTE:                  k = CL_QUOTE;
                CH_AMP:                    k = CL_AMP;
                CH_SEMI:                   k = CL_SEMI;
                CH_HASH:                   k = CL_HASH;
                CH_AT:                     k = CL_AT;
                default:                   k = CL_SYM;
            endcase
        end
        return k;
    endfunction

    function automatic logic single_class(char_class_t k);
        return (k == CL_PAREN) || (k == CL_BRACE) || (k == CL_AMP) ||
               (k == CL_SEMI) || (k == CL_HASH) || (k == CL_AT);
    endfunction

    // lit holds the word right-justified, first character in the top used byte
    function automatic logic tok_is(head8_t head, logic [3:0] len, logic [63:0] lit, int n);
        logic ok;
        ok = (len == 4'(n));
        for (int i = 0; i < 8; i++)
        begin
            if (i < n)
            begin
                if (head[i] != lit[8*(n-1-i) +: 8])
                begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

// ===== hdl/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer
// splits a byte stream into tokens and reports type, line and length of each
// ----------------------------------------------------------------------------
//
//  channel   dir  fields (lowest bit up)                         handshake
//  --------  ---  ---------------------------------------------  -----------------
//  s_*       in   tdata: char_in[7:0]; tlast: end_of_input       s_tvalid/s_tready
//  m_*       out  tuser: token_type[4:0];                        m_tvalid/m_tready
//                 tdata: line_number[31:0], token_length[15:0]
//
//  one byte per cycle while no result waits untaken: a byte goes into the input
//  register, then the per-byte update (class lookup, flag updates, keyword
//  compares) runs from that register into the tokenizer state and the result
//  register; a result is valid once its byte has passed both registers
//  reset clears the tokenizer state; line count restarts at 1, also after tlast
//  when the result register is full and not taken, the input register holds
//  its byte and s_tready drops until the result is taken
//
module source_text_tokenizer #(
    parameter int HEAD_BYTES  = 8,
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // char_in[7:0]
    input  logic        s_tlast,    // end_of_input

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // line_number[31:0], token_length[47:32]
    output logic [4:0]  m_tuser     // token_type[4:0]
);
    import stt_pkg::*;

    `include "source_text_tokenizer_macros.svh"

    // input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // result register
    logic       out_valid_reg;
    tok_res_t   out_res_reg;

    logic       advance;
    logic       core_emit;
    tok_res_t   core_res;

    // the held byte moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // byte payload needs no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    stt_core #(
        .HEAD_BYTES  (HEAD_BYTES),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .char_in      (in_char_reg),
        .end_of_input (in_last_reg),
        .emit         (core_emit),
        .res          (core_res)
    );

    // a processed byte either loads a token or leaves the register empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= core_emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_emit)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.token_type;
    assign m_tdata  = {out_res_reg.token_length, out_res_reg.line_number};

    // input side stalls only behind a full, untaken result
    `STT_ASSERT_IMP(a_stall_cause, !s_tready, m_tvalid && !m_tready)
    // line count starts at 1 and saturates, never zero
    `STT_ASSERT_IMP(a_line_nonzero, m_tvalid, m_tdata[31:0] != 32'd0)
    // every emitted token holds at least one byte
    `STT_ASSERT_IMP(a_len_nonzero, m_tvalid, m_tdata[47:32] != 16'd0)
    // the result type stays a defined code
    `STT_ASSERT_NXT(a_type_range, m_tvalid, m_tuser <= TT_ERROR)

endmodule

// ===== hdl/stt_match.sv =====
// ----------------------------------------------------------------------------
// stt_match
// classifies a finished token from its class, head bytes, length and flags
// ----------------------------------------------------------------------------
module stt_match #(
    parameter int LENGTH_BITS = 16
) (
    input  stt_pkg::char_class_t   cls,
    input  stt_pkg::head8_t        head,
    input  logic [LENGTH_BITS-1:0] len,
    input  logic                   saw_letter,
    input  logic                   saw_dot,
    output stt_pkg::tok_type_t     token_type,
    output logic                   starts_comment
);
    import stt_pkg::*;

    logic [3:0] len_q;
    logic       kw_hit;
    logic       op_hit;

    always_comb
    begin
        // anything longer than eight bytes never matches a word
        len_q = (len <= LENGTH_BITS'(8)) ? len[3:0] : 4'hF;

        starts_comment = tok_is(head, len_q, "//", 2);

        kw_hit = tok_is(head, len_q, "fn", 2)     | tok_is(head, len_q, "let", 3) |
                 tok_is(head, len_q, "comptime", 8) | tok_is(head, len_q, "assert", 6) |
                 tok_is(head, len_q, "test", 4)   | tok_is(head, len_q, "if", 2) |
                 tok_is(head, len_q, "else", 4)   | tok_is(head, len_q, "extern", 6);

        op_hit = tok_is(head, len_q, "+", 1)  | tok_is(head, len_q, "-", 1) |
                 tok_is(head, len_q, "*", 1)  | tok_is(head, len_q, "/", 1) |
                 tok_is(head, len_q, "=>", 2) | tok_is(head, len_q, ":", 1);

        unique case (cls)
            CL_ALPHA:
                token_type = kw_hit ? TT_KEYWORD : TT_IDENT;
            CL_PAREN:
                if (tok_is(head, len_q, "(", 1))
                    token_type = TT_LPAREN;
                else if (tok_is(head, len_q, ")", 1))
                    token_type = TT_RPAREN;
                else
                    token_type = TT_ERROR;
            CL_BRACE:
                if (tok_is(head, len_q, "{", 1))
                    token_type = TT_LBRACE;
                else if (tok_is(head, len_q, "}", 1))
                    token_type = TT_RBRACE;
                else
                    token_type = TT_ERROR;
            CL_NUM:
                if (tok_is(head, len_q, "...", 3))
                    token_type = TT_ELLIPSIS;
                else if (saw_letter)
                    token_type = TT_IDENT;
                else
                    token_type = saw_dot ? TT_FLOAT : TT_INT;
            CL_SYM:
                if (tok_is(head, len_q, ",", 1))
                    token_type = TT_COMMA;
                else
                    token_type = op_hit ? TT_OP : TT_INVALID;
            CL_QUOTE: token_type = TT_STRING;
            CL_AMP:   token_type = TT_AMP;
            CL_SEMI:  token_type = TT_SEMI;
            CL_AT:    token_type = TT_AT;
            CL_HASH:  token_type = TT_HASH;
            default:  token_type = TT_ERROR;
        endcase
    end

endmodule

// ===== hdl/stt_core.sv =====
// ----------------------------------------------------------------------------
// stt_core
// tokenizer state and the per-byte update, one byte per step
// ----------------------------------------------------------------------------
module stt_core #(
    parameter int HEAD_BYTES  = 8,
    parameter int LENGTH_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        char_in,
    input  logic              end_of_input,
    output logic              emit,
    output stt_pkg::tok_res_t res
);
    import stt_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    char_class_t            prev_reg,    prev_next;
    logic                   string_reg,  string_next;
    logic                   comment_reg, comment_next;
    logic                   esc_reg,     esc_next;
    logic [31:0]            line_reg,    line_next;
    logic [LENGTH_BITS-1:0] len_reg,     len_next;
    logic                   letter_reg,  letter_next;
    logic                   dot_reg,     dot_next;
    logic [7:0]             head_reg  [HEAD_BYTES];
    logic [7:0]             head_next [HEAD_BYTES];

    head8_t                 head8;
    logic [LENGTH_BITS-1:0] len_eff;
    tok_type_t              match_type;
    logic                   match_comment;

    char_class_t            nc;
    logic                   brk;
    logic                   add_nul;
    logic [LENGTH_BITS-1:0] base_len;
    logic [LENGTH_BITS-1:0] mid_len;
    logic [7:0]             esc_byte;
    logic [31:0]            len32;

    function automatic logic [LENGTH_BITS-1:0] len_inc(logic [LENGTH_BITS-1:0] x);
        return (x == LEN_MAX) ? x : x + 1'b1;
    endfunction

    // view used for matching; a pending escape at the end appends a backslash
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            head8[i] = (end_of_input && esc_reg && (len_reg == LENGTH_BITS'(i))) ?
                       CH_BSLASH : head_reg[i];
        end
        len_eff = (end_of_input && esc_reg) ? len_inc(len_reg) : len_reg;
    end

    stt_match #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_match (
        .cls            (prev_reg),
        .head           (head8),
        .len            (len_eff),
        .saw_letter     (letter_reg),
        .saw_dot        (dot_reg),
        .token_type     (match_type),
        .starts_comment (match_comment)
    );

    always_comb
    begin
        prev_next    = prev_reg;
        string_next  = string_reg;
        comment_next = comment_reg;
        esc_next     = esc_reg;
        line_next    = line_reg;
        len_next     = len_reg;
        letter_next  = letter_reg;
        dot_next     = dot_reg;
        head_next    = head_reg;
        emit         = 1'b0;
        nc           = class_of(char_in);
        brk          = 1'b0;
        add_nul      = 1'b0;
        base_len     = len_reg;
        mid_len      = len_reg;
        esc_byte     = (char_in == CH_LOW_N) ? CH_LF :
                       ((char_in == CH_LOW_T) ? CH_TAB : char_in);

        if (end_of_input)
        begin
            emit = (len_eff != '0) && (prev_reg != CL_FORMAT) && (prev_reg != CL_INVALID) &&
                   (!comment_reg || string_reg);
            prev_next    = CL_INVALID;
            string_next  = 1'b0;
            comment_next = 1'b0;
            esc_next     = 1'b0;
            line_next    = 32'd1;
            len_next     = '0;
            letter_next  = 1'b0;
            dot_next     = 1'b0;
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            for (int i = 0; i < HEAD_BYTES; i++)
            begin
                if (len_reg == LENGTH_BITS'(i))
                    head_next[i] = esc_byte;
            end
            letter_next = letter_reg | is_letter(esc_byte);
            dot_next    = dot_reg | (esc_byte == CH_DOT);
            len_next    = len_inc(len_reg);
        end
        else if (char_in == CH_BSLASH)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            brk = !string_reg &&
                  ((nc != prev_reg) || single_class(nc) || single_class(prev_reg)) &&
                  !((nc == CL_NUM) && (prev_reg == CL_ALPHA));
            letter_next = letter_reg;
            dot_next    = dot_reg;
            if (brk)
            begin
                if (match_comment)
                    comment_next = 1'b1;
                emit = (prev_reg != CL_INVALID) && (prev_reg != CL_FORMAT) &&
                       !(comment_reg || match_comment);
                base_len    = '0;
                letter_next = 1'b0;
                dot_next    = 1'b0;
            end

            // closing quote puts a nul before the quote byte
            if (nc == CL_QUOTE)
            begin
                add_nul     = string_reg;
                string_next = !string_reg;
            end
            if (char_in == CH_LF)
            begin
                if (line_reg != 32'hFFFF_FFFF)
                    line_next = line_reg + 32'd1;
                comment_next = 1'b0;
            end

            mid_len = add_nul ? len_inc(base_len) : base_len;
            for (int i = 0; i < HEAD_BYTES; i++)
            begin
                if (add_nul && (base_len == LENGTH_BITS'(i)))
                    head_next[i] = CH_NUL;
                if (mid_len == LENGTH_BITS'(i))
                    head_next[i] = char_in;
            end
            letter_next = letter_next | is_letter(char_in);
            dot_next    = dot_next | (char_in == CH_DOT);
            len_next    = len_inc(mid_len);
            prev_next   = nc;
        end

        len32                = 32'(len_eff);
        res.token_type       = match_type;
        res.line_number      = line_reg;
        res.token_length     = (len32 > 32'h0000_FFFF) ? 16'hFFFF : len32[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= CL_INVALID;
            string_reg  <= 1'b0;
            comment_reg <= 1'b0;
            esc_reg     <= 1'b0;
            line_reg    <= 32'd1;
            len_reg     <= '0;
            letter_reg  <= 1'b0;
            dot_reg     <= 1'b0;
        end
        else if (step)
        begin
            prev_reg    <= prev_next;
            string_reg  <= string_next;
            comment_reg <= comment_next;
            esc_reg     <= esc_next;
            line_reg    <= line_next;
            len_reg     <= len_next;
            letter_reg  <= letter_next;
            dot_reg     <= dot_next;
        end
    end

    // head bytes are payload, only entries below the length are read
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            head_reg <= head_next;
        end
    end

endmodule

// ===== bench/tb_source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer
// self-checking bench for the source text tokenizer: a queue of source bytes
// feeds a bursty stream driver, a bit-exact tokenizer model predicts every
// emitted token at input acceptance, and a monitor checks type, line and
// length of each output transaction against the oldest prediction
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer;

    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int HEAD_N   = 8;
    localparam int LEN_W    = 16;
    localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;

    // number of random source bytes after the directed stream
    localparam int RANDOM_BYTES = 1950;

    // one source byte waiting to be driven
    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        bit         drain;    // hold this byte back until all tokens are out
    } src_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [4:0]  m_tuser;

    src_byte_t   byte_queue[$];
    tok_res_t    token_queue[$];
    bit          next_drain = 1'b0;
    int unsigned total_bytes = 0;
    int unsigned accepted_bytes = 0;
    int unsigned tokens_seen = 0;
    int unsigned mismatch_count = 0;

    string kw_list[8] = '{"fn", "let", "comptime", "assert", "test", "if", "else", "extern"};
    string op_list[6] = '{"+", "-", "*", "/", "=>", ":"};
    string sym_chars = "+-*/=:<>!%^|~?,";
    string lone_chars = "(){}&;@#";

    // tokenizer model state
    char_class_t cur_class;
    bit          in_quote;
    bit          in_remark;
    bit          esc_wait;
    logic [31:0] line_cnt;
    int unsigned tok_bytes;
    bit          has_letter;
    bit          has_period;
    logic [7:0]  head_buf [HEAD_N];

    source_text_tokenizer #(
        .HEAD_BYTES  (HEAD_N),
        .LENGTH_BITS (LEN_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // tokenizer model
    // ------------------------------------------------------------------------

    function automatic bit is_alpha_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic char_class_t byte_class(logic [7:0] c);
        if (is_alpha_char(c) || c == CH_USCORE)
            return CL_ALPHA;
        if ((c >= "0" && c <= "9") || c == CH_DOT)
            return CL_NUM;
        case (c)
            CH_LPAREN, CH_RPAREN:    return CL_PAREN;
            CH_LBRACE, CH_RBRACE:    return CL_BRACE;
            CH_SPACE, CH_LF, CH_TAB: return CL_FORMAT;
            CH_QUOTE:                return CL_QUOTE;
            CH_AMP:                  return CL_AMP;
            CH_SEMI:                 return CL_SEMI;
            CH_HASH:                 return CL_HASH;
            CH_AT:                   return CL_AT;
            default:                 return CL_SYM;
        endcase
    endfunction

    // classes that always stand as a token of their own
    function automatic bit lone_class(char_class_t k);
        return k == CL_PAREN || k == CL_BRACE || k == CL_AMP ||
               k == CL_SEMI || k == CL_HASH || k == CL_AT;
    endfunction

    function automatic bit head_equals(string s);
        int n;
        n = s.len();
        if (tok_bytes != n || n > HEAD_N)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (head_buf[i] != s[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic tok_type_t token_kind(char_class_t k);
        case (k)
            CL_ALPHA:
            begin
                foreach (kw_list[i])
                begin
                    if (head_equals(kw_list[i]))
                        return TT_KEYWORD;
                end
                return TT_IDENT;
            end
            CL_PAREN:
            begin
                if (head_equals("("))
                    return TT_LPAREN;
                if (head_equals(")"))
                    return TT_RPAREN;
                return TT_ERROR;
            end
            CL_BRACE:
            begin
                if (head_equals("{"))
                    return TT_LBRACE;
                if (head_equals("}"))
                    return TT_RBRACE;
                return TT_ERROR;
            end
            CL_NUM:
            begin
                if (head_equals("..."))
                    return TT_ELLIPSIS;
                if (has_letter)
                    return TT_IDENT;
                return has_period ? TT_FLOAT : TT_INT;
            end
            CL_SYM:
            begin
                if (head_equals(","))
                    return TT_COMMA;
                foreach (op_list[i])
                begin
                    if (head_equals(op_list[i]))
                        return TT_OP;
                end
                return TT_INVALID;
            end
            CL_QUOTE: return TT_STRING;
            CL_AMP:   return TT_AMP;
            CL_SEMI:  return TT_SEMI;
            CL_AT:    return TT_AT;
            CL_HASH:  return TT_HASH;
            default:  return TT_ERROR;
        endcase
    endfunction

    task automatic clear_token();
        tok_bytes = 0;
        has_letter = 1'b0;
        has_period = 1'b0;
    endtask

    task automatic clear_stream();
        cur_class = CL_INVALID;
        in_quote = 1'b0;
        in_remark = 1'b0;
        esc_wait = 1'b0;
        line_cnt = 32'd1;
        clear_token();
        foreach (head_buf[i])
            head_buf[i] = 8'h00;
    endtask

    task automatic append_char(logic [7:0] b);
        if (tok_bytes < HEAD_N)
            head_buf[tok_bytes] = b;
        if (is_alpha_char(b))
            has_letter = 1'b1;
        if (b == CH_DOT)
            has_period = 1'b1;
        if (tok_bytes < LEN_MAX)
            tok_bytes++;
    endtask

    task automatic emit_token();
        tok_res_t r;
        r.token_type = token_kind(cur_class);
        r.line_number = line_cnt;
        r.token_length = tok_bytes[15:0];
        token_queue = {token_queue, r};
    endtask

    // advance the model by one accepted source byte
    task automatic tokenize_byte(logic [7:0] c, logic eoi);
        char_class_t nc;
        if (eoi)
        begin
            // a dangling backslash stays in the token as itself
            if (esc_wait)
                append_char(CH_BSLASH);
            if (tok_bytes != 0 && cur_class != CL_FORMAT && cur_class != CL_INVALID &&
                (!in_remark || in_quote))
                emit_token();
            clear_stream();
            return;
        end
        if (esc_wait)
        begin
            esc_wait = 1'b0;
            append_char(c == CH_LOW_N ? CH_LF : (c == CH_LOW_T ? CH_TAB : c));
            return;
        end
        if (c == CH_BSLASH)
        begin
            esc_wait = 1'b1;
            return;
        end
        nc = byte_class(c);
        // token boundary, digits and dots right after a letter continue it
        if (!in_quote && (nc != cur_class || lone_class(nc) || lone_class(cur_class)) &&
            !(nc == CL_NUM && cur_class == CL_ALPHA))
        begin
            if (head_equals("//"))
                in_remark = 1'b1;
            if (cur_class != CL_INVALID && cur_class != CL_FORMAT && !in_remark)
                emit_token();
            clear_token();
        end
        if (nc == CL_QUOTE)
        begin
            if (in_quote)
                append_char(CH_NUL);
            in_quote = !in_quote;
        end
        if (c == CH_LF)
        begin
            if (line_cnt != 32'hFFFF_FFFF)
                line_cnt++;
            in_remark = 1'b0;
        end
        append_char(c);
        cur_class = nc;
    endtask

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------

    task automatic put_byte(logic [7:0] c);
        src_byte_t b;
        b.ch = c;
        b.eoi = 1'b0;
        b.drain = next_drain;
        next_drain = 1'b0;
        byte_queue = {byte_queue, b};
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    // end of stream, the byte beside it is don't-care
    task automatic put_end();
        src_byte_t b;
        b.ch = 8'($urandom_range(0, 255));
        b.eoi = 1'b1;
        b.drain = next_drain;
        next_drain = 1'b0;
        byte_queue = {byte_queue, b};
    endtask

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        return CH_USCORE;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // printable byte that neither opens an escape nor closes a string
    function automatic logic [7:0] rand_plain();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == CH_QUOTE || c == CH_BSLASH)
            c = "a";
        return c;
    endfunction

    function automatic logic [7:0] rand_escape();
        case ($urandom_range(0, 4))
            0:       return CH_LOW_N;
            1:       return CH_LOW_T;
            2:       return CH_QUOTE;
            3:       return CH_BSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_LF;
        endcase
    endfunction

    // one random lexical fragment, mostly well-formed tokens
    task automatic put_fragment();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 10)
            put_text(kw_list[$urandom_range(0, 7)]);
        else if (r < 14)
        begin
            // keyword followed by more letters, which can run past the head buffer
            put_text(kw_list[$urandom_range(0, 7)]);
            n = $urandom_range(1, 6);
            repeat (n) put_byte(rand_alpha());
        end
        else if (r < 24)
        begin
            n = $urandom_range(0, 9);
            put_byte(rand_alpha());
            repeat (n)
            begin
                if ($urandom_range(0, 2) == 0)
                    put_byte(rand_digit());
                else if ($urandom_range(0, 9) == 0)
                    put_byte(CH_DOT);
                else
                    put_byte(rand_alpha());
            end
        end
        else if (r < 32)
        begin
            n = $urandom_range(1, 6);
            repeat (n) put_byte(rand_digit());
        end
        else if (r < 37)
        begin
            n = $urandom_range(0, 3);
            repeat (n) put_byte(rand_digit());
            put_byte(CH_DOT);
            n = $urandom_range(0, 3);
            repeat (n) put_byte(rand_digit());
        end
        else if (r < 39)
            put_text("...");
        else if (r < 45)
            put_text(op_list[$urandom_range(0, 5)]);
        else if (r < 47)
            put_text(",");
        else if (r < 52)
        begin
            n = $urandom_range(1, 3);
            repeat (n) put_byte(sym_chars[$urandom_range(0, sym_chars.len() - 1)]);
        end
        else if (r < 60)
            put_byte(lone_chars[$urandom_range(0, 7)]);
        else if (r < 67)
        begin
            put_byte(CH_QUOTE);
            n = $urandom_range(0, 8);
            repeat (n)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    put_byte(CH_BSLASH);
                    put_byte(rand_escape());
                end
                else
                    put_byte(rand_plain());
            end
            put_byte(CH_QUOTE);
        end
        else if (r < 71)
        begin
            put_text("//");
            n = $urandom_range(0, 8);
            repeat (n) put_byte(rand_plain());
            put_byte(CH_LF);
        end
        else if (r < 80)
        begin
            n = $urandom_range(1, 3);
            repeat (n) put_byte(rand_space());
        end
        else if (r < 88)
        begin
            // raw noise, any byte including high ones
            n = $urandom_range(1, 3);
            repeat (n) put_byte(8'($urandom_range(0, 255)));
        end
        else if (r < 92)
        begin
            put_byte(CH_BSLASH);
            put_byte(rand_escape());
        end
        else if (r < 94)
        begin
            // paren or brace token with an escaped byte inside
            put_byte($urandom_range(0, 1) ? CH_LPAREN : CH_LBRACE);
            put_byte(CH_BSLASH);
            put_byte(rand_escape());
        end
        else if (r < 97)
        begin
            n = $urandom_range(2, 6);
            repeat (n) put_byte($urandom_range(0, 1) ? CH_DOT : rand_digit());
        end
        else
        begin
            // end of stream in various open states
            case ($urandom_range(0, 3))
                0: ;
                1: put_byte(CH_BSLASH);
                2:
                begin
                    put_byte(CH_QUOTE);
                    put_byte(rand_alpha());
                end
                default:
                begin
                    put_text("//");
                    put_byte(rand_alpha());
                end
            endcase
            put_end();
        end
    endtask

    task automatic build_stimulus();
        // directed stream: keyword, braces, paren with escape, string escape,
        // float, semicolon, comment, ellipsis, comma, hash, at, amp, high byte
        // and a backslash left open at the end
        put_text("fn{(\\)}\"\\t\"2.;//");
        put_byte(CH_LF);
        put_text("...,#@&");
        put_byte(8'hFF);
        put_byte(CH_BSLASH);
        put_end();

        // random part, starts after everything so far has drained
        next_drain = 1'b1;
        while (byte_queue.size() < 27 + RANDOM_BYTES)
        begin
            if ($urandom_range(0, 299) == 0)
                next_drain = 1'b1;
            put_fragment();
            if ($urandom_range(0, 1) == 0)
                put_byte(rand_space());
        end
        put_end();
        total_bytes = byte_queue.size();
    endtask

    // ------------------------------------------------------------------------
    // source driver: bursts with random gaps, model updated on acceptance
    // ------------------------------------------------------------------------
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        src_byte_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tlast <= 1'b0;
            burst_left = 0;
            gap_left = 0;
            clear_stream();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                tokenize_byte(s_tdata, s_tlast);
                accepted_bytes++;
            end
            // a transaction on offer stays put until it is taken
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (byte_queue.size() > 0 &&
                         !(byte_queue[0].drain && token_queue.size() != 0))
                begin
                    nxt = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.ch;
                    s_tlast <= nxt.eoi;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 60);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sink ready pattern with one long hold-off
    // ------------------------------------------------------------------------
    int unsigned ready_mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            ready_mode = 0;
            mode_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            // once traffic flows, back off long enough to fill the block
            if (!hold_done && tokens_seen >= 100)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(32, 256);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (ready_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // token monitor: every output transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        tok_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            tokens_seen++;
            if (token_queue.size() == 0)
            begin
                $display("%0t: unexpected token, type %0d line %0d length %0d",
                         $time, m_tuser, m_tdata[31:0], m_tdata[47:32]);
                mismatch_count++;
            end
            else
            begin
                want = token_queue.pop_front();
                if (m_tuser !== want.token_type)
                begin
                    $display("%0t: token_type expected %0d got %0d",
                             $time, want.token_type, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[31:0] !== want.line_number)
                begin
                    $display("%0t: line_number expected %0d got %0d",
                             $time, want.line_number, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[47:32] !== want.token_length)
                begin
                    $display("%0t: token_length expected %0d got %0d",
                             $time, want.token_length, m_tdata[47:32]);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned settle;
        build_stimulus();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (accepted_bytes < total_bytes)
            @(posedge clk);
        settle = 0;
        while (token_queue.size() != 0 && settle < 5000)
        begin
            @(posedge clk);
            settle++;
        end
        if (token_queue.size() != 0)
        begin
            $display("%0t: %0d expected tokens never arrived", $time, token_queue.size());
            mismatch_count++;
        end
        // pipeline is two deep, leave room for any stray transaction
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #30_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== source_text_tokenizer.f =====
+incdir+hdl
hdl/stt_pkg.sv
hdl/stt_match.sv
hdl/stt_core.sv
hdl/source_text_tokenizer.sv
bench/tb_source_text_tokenizer.sv
